FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the duty regulator.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds on the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent holds, the consequent holds on the following edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bbsdr_pkg.sv
// Shared types and constants of the buck/boost step duty regulator.
// No dependencies; used by every module of the block.
package bbsdr_pkg;

   localparam int unsigned SampleWidth  = 12;
   localparam int unsigned DutyWidth    = 14;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   typedef logic [SampleWidth-1:0] sample_type;
   typedef logic [DutyWidth-1:0]   duty_type;

   localparam duty_type   DutyFull            = 14'd10000;
   localparam sample_type VoltTargetReset     = 12'd0;
   localparam sample_type CurrLimitReset      = 12'd4095;
   localparam duty_type   BuckStepReset       = 14'd1000;
   localparam duty_type   BoostStepReset      = 14'd100;
   localparam sample_type SolarMinVoltReset   = 12'd0;
   localparam duty_type   BoostMaxDutyReset   = DutyFull;

   typedef enum logic [2:0] {
      CsrBuckVoltTarget  = 3'd0,
      CsrBuckCurrLimit   = 3'd1,
      CsrBuckStep        = 3'd2,
      CsrBoostVoltTarget = 3'd3,
      CsrBoostCurrLimit  = 3'd4,
      CsrBoostStep       = 3'd5,
      CsrSolarMinVolt    = 3'd6,
      CsrBoostMaxDuty    = 3'd7
   } csr_index_type;

   typedef struct packed {
      sample_type buck_volt_sample;
      sample_type buck_curr_sample;
      sample_type boost_volt_sample;
      sample_type boost_curr_sample;
      sample_type solar_volt_sample;
   } req_data_type;

   typedef struct packed {
      duty_type buck_duty_out;
      logic     buck_updated;
      duty_type boost_duty_out;
      logic     boost_updated;
   } rsp_data_type;

   typedef struct packed {
      duty_type duty;
      logic     updated;
   } duty_result_type;

endpackage

FILE: rtl/bbsdr_duty_step.sv
// One converter's duty update: overcurrent back-off, forced zero and step toward the target.
// Depends on bbsdr_pkg.
module bbsdr_duty_step (
   input  bbsdr_pkg::duty_type        duty_cur,
   input  bbsdr_pkg::duty_type        step,
   input  bbsdr_pkg::duty_type        ceiling,
   input  bbsdr_pkg::sample_type      volt_sample,
   input  bbsdr_pkg::sample_type      volt_target,
   input  bbsdr_pkg::sample_type      curr_sample,
   input  bbsdr_pkg::sample_type      curr_limit,
   input  logic                       force_zero,
   output bbsdr_pkg::duty_result_type result
);
   import bbsdr_pkg::*;

   logic [DutyWidth:0] sum;
   duty_type           duty_up;
   duty_type           duty_down;

   assign sum       = {1'b0, duty_cur} + {1'b0, step};
   assign duty_up   = (sum > {1'b0, ceiling}) ? ceiling : sum[DutyWidth-1:0];
   assign duty_down = (step >= duty_cur) ? '0 : duty_cur - step;

   // Overcurrent wins over everything, then the forced zero, then the voltage error.
   always_comb begin
      result.duty    = duty_cur;
      result.updated = 1'b1;
      if (curr_sample > curr_limit) begin
         result.duty = duty_down;
      end else if (force_zero) begin
         result.duty = '0;
      end else if (volt_sample < volt_target) begin
         result.duty = duty_up;
      end else if (volt_sample > volt_target) begin
         result.duty = duty_down;
      end else begin
         result.updated = 1'b0;
      end
   end

endmodule

FILE: rtl/buck_boost_step_duty_regulator_unit.sv
// Path: an accepted transaction is held in the input register, goes through the duty update
// stage and is written to the output register, from which the result is taken; stalls hold it.
// Throughput: one transaction per cycle without stalls; the single update stage sets this.
// Reset (synchronous, active high) clears both duties, empties the input and output
// registers and returns every configuration register to its default.
// Depends on bbsdr_pkg, bbsdr_duty_step and assert_macros.svh.
`include "assert_macros.svh"

module buck_boost_step_duty_regulator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bbsdr_pkg::req_data_type             req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bbsdr_pkg::rsp_data_type             rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bbsdr_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [bbsdr_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [bbsdr_pkg::CsrDataWidth-1:0]  prdata,
   output logic                                pready
);
   import bbsdr_pkg::*;

   sample_type      buck_volt_target_ff;
   sample_type      buck_curr_limit_ff;
   duty_type        buck_step_ff;
   sample_type      boost_volt_target_ff;
   sample_type      boost_curr_limit_ff;
   duty_type        boost_step_ff;
   sample_type      solar_min_volt_ff;
   duty_type        boost_max_duty_ff;

   logic            in_valid_ff;
   req_data_type    in_data_ff;
   logic            out_valid_ff;
   rsp_data_type    out_data_ff;
   duty_type        buck_duty_ff;
   duty_type        boost_duty_ff;
   duty_type        buck_duty_in;
   duty_type        boost_duty_in;

   csr_index_type   csr_index;
   logic            csr_write;
   logic            out_ready;
   logic            fire;
   duty_type        boost_ceiling;
   duty_result_type buck_result;
   duty_result_type boost_result;

   assign csr_index = csr_index_type'(paddr[CsrAddrWidth-1:2]);
   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         buck_volt_target_ff  <= VoltTargetReset;
         buck_curr_limit_ff   <= CurrLimitReset;
         buck_step_ff         <= BuckStepReset;
         boost_volt_target_ff <= VoltTargetReset;
         boost_curr_limit_ff  <= CurrLimitReset;
         boost_step_ff        <= BoostStepReset;
         solar_min_volt_ff    <= SolarMinVoltReset;
         boost_max_duty_ff    <= BoostMaxDutyReset;
      end else if (csr_write) begin
         case (csr_index)
            CsrBuckVoltTarget:  buck_volt_target_ff  <= pwdata[SampleWidth-1:0];
            CsrBuckCurrLimit:   buck_curr_limit_ff   <= pwdata[SampleWidth-1:0];
            CsrBuckStep:        buck_step_ff         <= pwdata[DutyWidth-1:0];
            CsrBoostVoltTarget: boost_volt_target_ff <= pwdata[SampleWidth-1:0];
            CsrBoostCurrLimit:  boost_curr_limit_ff  <= pwdata[SampleWidth-1:0];
            CsrBoostStep:       boost_step_ff        <= pwdata[DutyWidth-1:0];
            CsrSolarMinVolt:    solar_min_volt_ff    <= pwdata[SampleWidth-1:0];
            CsrBoostMaxDuty:    boost_max_duty_ff    <= pwdata[DutyWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CsrBuckVoltTarget:  prdata = CsrDataWidth'(buck_volt_target_ff);
         CsrBuckCurrLimit:   prdata = CsrDataWidth'(buck_curr_limit_ff);
         CsrBuckStep:        prdata = CsrDataWidth'(buck_step_ff);
         CsrBoostVoltTarget: prdata = CsrDataWidth'(boost_volt_target_ff);
         CsrBoostCurrLimit:  prdata = CsrDataWidth'(boost_curr_limit_ff);
         CsrBoostStep:       prdata = CsrDataWidth'(boost_step_ff);
         CsrSolarMinVolt:    prdata = CsrDataWidth'(solar_min_volt_ff);
         CsrBoostMaxDuty:    prdata = CsrDataWidth'(boost_max_duty_ff);
         default:            prdata = '0;
      endcase
   end

   // The update stage moves whenever the output register is empty or being emptied.
   assign out_ready = ~out_valid_ff | ~rsp_stall;
   assign fire      = in_valid_ff & out_ready;
   assign req_stall = in_valid_ff & ~out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   assign boost_ceiling = (boost_max_duty_ff > DutyFull) ? DutyFull : boost_max_duty_ff;

   bbsdr_duty_step u_buck_step (
      .duty_cur    (buck_duty_ff),
      .step        (buck_step_ff),
      .ceiling     (DutyFull),
      .volt_sample (in_data_ff.buck_volt_sample),
      .volt_target (buck_volt_target_ff),
      .curr_sample (in_data_ff.buck_curr_sample),
      .curr_limit  (buck_curr_limit_ff),
      .force_zero  (1'b0),
      .result      (buck_result)
   );

   bbsdr_duty_step u_boost_step (
      .duty_cur    (boost_duty_ff),
      .step        (boost_step_ff),
      .ceiling     (boost_ceiling),
      .volt_sample (in_data_ff.boost_volt_sample),
      .volt_target (boost_volt_target_ff),
      .curr_sample (in_data_ff.boost_curr_sample),
      .curr_limit  (boost_curr_limit_ff),
      .force_zero  (in_data_ff.solar_volt_sample < solar_min_volt_ff),
      .result      (boost_result)
   );

   assign buck_duty_in  = buck_result.duty;
   assign boost_duty_in = boost_result.duty;

   always_ff @(posedge clock) begin
      if (reset) begin
         buck_duty_ff  <= '0;
         boost_duty_ff <= '0;
      end else if (fire) begin
         buck_duty_ff  <= buck_duty_in;
         boost_duty_ff <= boost_duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff.buck_duty_out  <= buck_duty_in;
         out_data_ff.buck_updated   <= buck_result.updated;
         out_data_ff.boost_duty_out <= boost_duty_in;
         out_data_ff.boost_updated  <= boost_result.updated;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `ASSERT_ALWAYS(a_buck_duty_range, buck_duty_ff <= DutyFull, "buck duty above full scale")
   `ASSERT_ALWAYS(a_boost_duty_range, boost_duty_ff <= DutyFull, "boost duty above full scale")
   `ASSERT_NEXT(a_result_tracks_state, fire,
      rsp_valid && rsp_data.buck_duty_out == buck_duty_ff
      && rsp_data.boost_duty_out == boost_duty_ff, "result register disagrees with duty state")
   `ASSERT_NEXT(a_state_holds_when_idle, !fire,
      $stable(buck_duty_ff) && $stable(boost_duty_ff), "duty changed without a transaction")

endmodule

FILE: sim/buck_boost_step_duty_regulator_unit_tb.sv
// Self-checking testbench for the buck/boost step duty regulator: directed and random ADC sample
// sets under several register settings, checked against an in-bench duty predictor.
// Depends on bbsdr_pkg and the buck_boost_step_duty_regulator_unit RTL.
`timescale 1ns / 100ps

module buck_boost_step_duty_regulator_unit_tb;
   import bbsdr_pkg::*;

   localparam int QuietLimit    = 2000;
   localparam int RandomPhases  = 8;
   localparam int ItemsPerPhase = 210;

   typedef enum {StallNone, StallAlternate, StallSparse, StallLong} stall_pattern_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_data_type            req_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   rsp_data_type            rsp_data;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   // Predictor state and a copy of the register file.
   duty_type     cfg_reg [8];
   duty_type     buck_duty_q = '0;
   duty_type     boost_duty_q = '0;
   rsp_data_type expected_duties [$];
   req_data_type sample_queue [$];

   int                mismatch_count = 0;
   int                samples_accepted = 0;
   int                results_checked = 0;
   int                reads_checked = 0;
   int                settings_count = 0;
   int                quiet_cycles = 0;
   int                burst_left;
   int                gap_left;
   int                gap_max = 15;
   int                stall_left;
   stall_pattern_type stall_mode;
   rsp_data_type      want;

   buck_boost_step_duty_regulator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic duty_type duty_down(input duty_type duty, input duty_type step);
      return (step >= duty) ? '0 : duty_type'(duty - step);
   endfunction

   function automatic duty_type duty_up(input duty_type duty, input duty_type step,
                                        input duty_type ceiling);
      int total;
      total = int'(duty) + int'(step);
      return (total > int'(ceiling)) ? ceiling : duty_type'(total);
   endfunction

   // Advances both duties by one sample set and returns the result it should produce.
   function automatic rsp_data_type predict_duties(input req_data_type s);
      rsp_data_type r;
      duty_type     ceiling;
      ceiling = (cfg_reg[CsrBoostMaxDuty] > DutyFull) ? DutyFull : cfg_reg[CsrBoostMaxDuty];
      r.buck_updated  = 1'b1;
      r.boost_updated = 1'b1;
      if (s.buck_curr_sample > cfg_reg[CsrBuckCurrLimit])
         buck_duty_q = duty_down(buck_duty_q, cfg_reg[CsrBuckStep]);
      else if (s.buck_volt_sample < cfg_reg[CsrBuckVoltTarget])
         buck_duty_q = duty_up(buck_duty_q, cfg_reg[CsrBuckStep], DutyFull);
      else if (s.buck_volt_sample > cfg_reg[CsrBuckVoltTarget])
         buck_duty_q = duty_down(buck_duty_q, cfg_reg[CsrBuckStep]);
      else
         r.buck_updated = 1'b0;
      // Overcurrent wins over the solar check, which in turn wins over regulation.
      if (s.boost_curr_sample > cfg_reg[CsrBoostCurrLimit])
         boost_duty_q = duty_down(boost_duty_q, cfg_reg[CsrBoostStep]);
      else if (s.solar_volt_sample < cfg_reg[CsrSolarMinVolt])
         boost_duty_q = '0;
      else if (s.boost_volt_sample < cfg_reg[CsrBoostVoltTarget])
         boost_duty_q = duty_up(boost_duty_q, cfg_reg[CsrBoostStep], ceiling);
      else if (s.boost_volt_sample > cfg_reg[CsrBoostVoltTarget])
         boost_duty_q = duty_down(boost_duty_q, cfg_reg[CsrBoostStep]);
      else
         r.boost_updated = 1'b0;
      r.buck_duty_out  = buck_duty_q;
      r.boost_duty_out = boost_duty_q;
      return r;
   endfunction

   function automatic req_data_type sample_set(input int bv, input int bi, input int ov,
                                               input int oi, input int sv);
      req_data_type s;
      s.buck_volt_sample  = sample_type'(bv);
      s.buck_curr_sample  = sample_type'(bi);
      s.boost_volt_sample = sample_type'(ov);
      s.boost_curr_sample = sample_type'(oi);
      s.solar_volt_sample = sample_type'(sv);
      return s;
   endfunction

   // Voltage close to its target, so that both directions and the hold case are frequent.
   function automatic int near_level(input duty_type level);
      int v;
      case ($urandom_range(7))
         0: v = int'(level);
         1, 2, 3: v = int'(level) + int'($urandom_range(128)) - 64;
         default: v = int'($urandom_range(4095));
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v;
   endfunction

   function automatic int current_level(input duty_type limit);
      case ($urandom_range(7))
         0, 1, 2, 3, 4: return int'($urandom_range(int'(limit)));
         5: return int'(limit);
         default: return int'($urandom_range(4095));
      endcase
   endfunction

   function automatic int solar_level(input duty_type min_volt);
      case ($urandom_range(7))
         0, 1, 2, 3, 4, 5: return int'($urandom_range(4095, int'(min_volt)));
         6: return int'(min_volt);
         default: return int'($urandom_range(4095));
      endcase
   endfunction

   function automatic int unsigned pick_setting(input int unsigned top, input int unsigned typical);
      case ($urandom_range(3))
         0: return 0;
         1: return top;
         default: return $urandom_range(typical);
      endcase
   endfunction

   task automatic csr_write(input csr_index_type idx, input int unsigned value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         CsrBuckStep, CsrBoostStep, CsrBoostMaxDuty: cfg_reg[idx] = value[13:0];
         default: cfg_reg[idx] = {2'b00, value[11:0]};
      endcase
   endtask

   // prdata is sampled in the middle of the access phase.
   task automatic csr_read_check(input csr_index_type idx);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      if (prdata !== {{(CsrDataWidth - DutyWidth){1'b0}}, cfg_reg[idx]})
         report_mismatch($sformatf("register %s reads %0d, expected %0d",
                                   idx.name(), prdata, cfg_reg[idx]));
      reads_checked++;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic program_registers(input int unsigned bvt, input int unsigned bcl,
                                    input int unsigned bst, input int unsigned ovt,
                                    input int unsigned ocl, input int unsigned ost,
                                    input int unsigned smv, input int unsigned omd);
      csr_write(CsrBuckVoltTarget, bvt);
      csr_write(CsrBuckCurrLimit, bcl);
      csr_write(CsrBuckStep, bst);
      csr_write(CsrBoostVoltTarget, ovt);
      csr_write(CsrBoostCurrLimit, ocl);
      csr_write(CsrBoostStep, ost);
      csr_write(CsrSolarMinVolt, smv);
      csr_write(CsrBoostMaxDuty, omd);
      for (int i = 0; i < 8; i++)
         csr_read_check(csr_index_type'(i));
      settings_count++;
   endtask

   // Returns once the sender has nothing left and every expected result has come back.
   // The check is made at the falling edge, when the rising-edge processes have settled.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || expected_duties.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0 || sample_queue.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end else begin
            req_data  <= sample_queue.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(40, 1);
               gap_left   = $urandom_range(gap_max);
            end
         end
      end
   end

   // Receiver: the stall pattern is picked at random and is picked anew when its countdown runs out.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode = StallNone;
         stall_left = 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_pattern_type'($urandom_range(3));
            stall_left = $urandom_range(200, 20);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            StallNone:      rsp_stall <= 1'b0;
            StallAlternate: rsp_stall <= stall_left[0];
            StallSparse:    rsp_stall <= ($urandom_range(3) == 0);
            default:        rsp_stall <= (stall_left % 16) < 9;
         endcase
      end
   end

   // Monitor: checks each result transaction, then predicts for each accepted sample set.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_duties.size() == 0) begin
               report_mismatch("result transaction with no sample set outstanding");
            end else begin
               want = expected_duties.pop_front();
               if (rsp_data.buck_duty_out !== want.buck_duty_out)
                  report_mismatch($sformatf("buck duty %0d, expected %0d",
                                            rsp_data.buck_duty_out, want.buck_duty_out));
               if (rsp_data.buck_updated !== want.buck_updated)
                  report_mismatch($sformatf("buck updated flag %b, expected %b",
                                            rsp_data.buck_updated, want.buck_updated));
               if (rsp_data.boost_duty_out !== want.boost_duty_out)
                  report_mismatch($sformatf("boost duty %0d, expected %0d",
                                            rsp_data.boost_duty_out, want.boost_duty_out));
               if (rsp_data.boost_updated !== want.boost_updated)
                  report_mismatch($sformatf("boost updated flag %b, expected %b",
                                            rsp_data.boost_updated, want.boost_updated));
               results_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            expected_duties.push_back(predict_duties(req_data));
            samples_accepted++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                  QuietLimit, expected_duties.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      cfg_reg[CsrBuckVoltTarget]  = duty_type'(VoltTargetReset);
      cfg_reg[CsrBuckCurrLimit]   = duty_type'(CurrLimitReset);
      cfg_reg[CsrBuckStep]        = BuckStepReset;
      cfg_reg[CsrBoostVoltTarget] = duty_type'(VoltTargetReset);
      cfg_reg[CsrBoostCurrLimit]  = duty_type'(CurrLimitReset);
      cfg_reg[CsrBoostStep]       = BoostStepReset;
      cfg_reg[CsrSolarMinVolt]    = duty_type'(SolarMinVoltReset);
      cfg_reg[CsrBoostMaxDuty]    = BoostMaxDutyReset;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 8; i++)
         csr_read_check(csr_index_type'(i));

      // Directed: clamps, holds, current exactly at the limit, overcurrent, solar cut-off.
      program_registers(2000, 3000, 4000, 2000, 3000, 2500, 1000, 6000);
      sample_queue.push_back(sample_set(0, 0, 0, 0, 0));
      sample_queue.push_back(sample_set(0, 3000, 0, 3000, 1000));
      sample_queue.push_back(sample_set(0, 0, 0, 0, 4095));
      sample_queue.push_back(sample_set(1999, 0, 1999, 0, 4095));
      sample_queue.push_back(sample_set(2000, 0, 2000, 0, 4095));
      sample_queue.push_back(sample_set(4095, 0, 4095, 0, 4095));
      sample_queue.push_back(sample_set(2000, 3001, 2000, 4095, 4095));
      sample_queue.push_back(sample_set(2000, 4095, 2000, 3001, 0));
      sample_queue.push_back(sample_set(2000, 4095, 0, 0, 999));
      repeat (3) sample_queue.push_back(sample_set(0, 0, 0, 0, 4095));
      wait_idle();

      // The boost duty now sits above the lowered clamp until it next steps up.
      csr_write(CsrBoostMaxDuty, 3000);
      sample_queue.push_back(sample_set(2000, 0, 2000, 0, 4095));
      sample_queue.push_back(sample_set(2000, 0, 0, 0, 4095));
      wait_idle();

      // Steps and the boost clamp beyond full scale.
      csr_write(CsrBuckStep, 16383);
      csr_write(CsrBoostStep, 16383);
      csr_write(CsrBoostMaxDuty, 16383);
      sample_queue.push_back(sample_set(0, 0, 0, 0, 4095));
      sample_queue.push_back(sample_set(4095, 0, 4095, 0, 4095));
      sample_queue.push_back(sample_set(0, 0, 0, 0, 4095));
      sample_queue.push_back(sample_set(4095, 4095, 4095, 4095, 4095));

      for (int phase = 0; phase < RandomPhases; phase++) begin
         wait_idle();
         case (phase)
            0: program_registers(0, 0, 0, 0, 0, 0, 0, 0);
            1: program_registers(4095, 4095, 16383, 4095, 4095, 16383, 4095, 16383);
            default: program_registers(pick_setting(4095, 4095), pick_setting(4095, 4095),
                                       pick_setting(16383, 2000), pick_setting(4095, 4095),
                                       pick_setting(4095, 4095), pick_setting(16383, 2000),
                                       pick_setting(4095, 4095), pick_setting(16383, 10000));
         endcase
         gap_max = (phase % 3 == 0) ? 0 : 15;
         for (int n = 0; n < ItemsPerPhase; n++) begin
            // Once in the run the sender holds off until everything has drained.
            if (phase == 3 && n == ItemsPerPhase / 2)
               wait_idle();
            sample_queue.push_back(sample_set(near_level(cfg_reg[CsrBuckVoltTarget]),
                                              current_level(cfg_reg[CsrBuckCurrLimit]),
                                              near_level(cfg_reg[CsrBoostVoltTarget]),
                                              current_level(cfg_reg[CsrBoostCurrLimit]),
                                              solar_level(cfg_reg[CsrSolarMinVolt])));
         end
      end
      wait_idle();

      $display("Covered %0d sample sets under %0d full register settings plus directed edits,",
               samples_accepted, settings_count);
      $display("with %0d results and %0d register reads checked; %0d mismatches.",
               results_checked, reads_checked, mismatch_count);
      if (mismatch_count == 0 && expected_duties.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bbsdr_pkg.sv
rtl/bbsdr_duty_step.sv
rtl/buck_boost_step_duty_regulator_unit.sv
sim/buck_boost_step_duty_regulator_unit_tb.sv
